/* src/cobb_pkg.sv */
// ----------------------------------------------------------------------------
// cobb_pkg
// shared types, widths and codes for the circle / oriented box overlap tester
// ----------------------------------------------------------------------------
package cobb_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int LEN_WIDTH   = COORD_WIDTH - 1;
  localparam int AXIS_WIDTH  = 16;
  localparam int AXIS_FRAC   = 14;
  localparam int DELTA_WIDTH = COORD_WIDTH + 1;
  localparam int PROJ_WIDTH  = DELTA_WIDTH + AXIS_WIDTH + 1;
  localparam int SQ_WIDTH    = 2 * DELTA_WIDTH + 1;
  localparam int DOT_WIDTH   = 2 * AXIS_WIDTH + 1;
  localparam int RDOT_WIDTH  = DOT_WIDTH - AXIS_FRAC + 1;
  localparam int EXT_WIDTH   = RDOT_WIDTH + LEN_WIDTH + 2;
  localparam int CMP_WIDTH   = PROJ_WIDTH + 4;
  localparam int QDEPTH      = 2;
  localparam int QPTR_WIDTH  = 1;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = COORD_WIDTH;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_TYPE   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_X      = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_Y      = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_AXIS_X = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_AXIS_Y = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HALF_W = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HALF_D = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RADIUS = 3'd7;

  typedef enum logic [3:0] {
    KIND_CC = 4'b0001,
    KIND_RB = 4'b0010,
    KIND_OB = 4'b0100,
    KIND_BB = 4'b1000
  } kind_t;

  typedef struct packed {
    logic                          req_type;
    logic                          other_type;
    logic signed [COORD_WIDTH-1:0] other_x;
    logic signed [COORD_WIDTH-1:0] other_y;
    logic signed [AXIS_WIDTH-1:0]  other_axis_x;
    logic signed [AXIS_WIDTH-1:0]  other_axis_y;
    logic [LEN_WIDTH-1:0]          other_half_w;
    logic [LEN_WIDTH-1:0]          other_half_d;
    logic [LEN_WIDTH-1:0]          other_radius;
  } req_t;

  typedef struct packed {
    logic                          ref_type;
    logic signed [COORD_WIDTH-1:0] ref_x;
    logic signed [COORD_WIDTH-1:0] ref_y;
    logic signed [AXIS_WIDTH-1:0]  ref_axis_x;
    logic signed [AXIS_WIDTH-1:0]  ref_axis_y;
    logic [LEN_WIDTH-1:0]          ref_half_w;
    logic [LEN_WIDTH-1:0]          ref_half_d;
    logic [LEN_WIDTH-1:0]          ref_radius;
  } cfg_t;

  // classified work item handed from front to back
  typedef struct packed {
    kind_t                         kind;
    logic                          point;
    logic signed [DELTA_WIDTH-1:0] dx;
    logic signed [DELTA_WIDTH-1:0] dy;
    logic [LEN_WIDTH:0]            reach;
    logic signed [AXIS_WIDTH-1:0]  ax;
    logic signed [AXIS_WIDTH-1:0]  ay;
    logic [LEN_WIDTH-1:0]          aw;
    logic [LEN_WIDTH-1:0]          ad;
    logic signed [AXIS_WIDTH-1:0]  bx;
    logic signed [AXIS_WIDTH-1:0]  by;
    logic [LEN_WIDTH-1:0]          bw;
    logic [LEN_WIDTH-1:0]          bd;
    logic [LEN_WIDTH:0]            grow;
  } work_t;

endpackage

/* src/cobb_if.sv */
// ----------------------------------------------------------------------------
// cobb_req_if / cobb_res_if / cobb_cfg_if
// valid-ready channels for requests, results and register writes
// ----------------------------------------------------------------------------
interface cobb_req_if import cobb_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cobb_res_if (input logic clk);
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, output hit, input ready);
  modport sink (input valid, input hit, output ready);
endinterface

interface cobb_cfg_if import cobb_pkg::*; (input logic clk);
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

/* src/cobb_front.sv */
// ----------------------------------------------------------------------------
// cobb_front
// register file, delta and pair classification of each request
// ----------------------------------------------------------------------------
module cobb_front import cobb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  cobb_cfg_if.sink        cfg,
  input  req_t            in_data,
  output work_t           work
);

  cfg_t regs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{ref_type: 1'b0, ref_x: '0, ref_y: '0, ref_axis_x: '0,
                ref_axis_y: AXIS_WIDTH'(1 << AXIS_FRAC), ref_half_w: '0,
                ref_half_d: '0, ref_radius: '0};
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TYPE:   regs.ref_type   <= cfg.wdata[0];
        REG_X:      regs.ref_x      <= cfg.wdata[COORD_WIDTH-1:0];
        REG_Y:      regs.ref_y      <= cfg.wdata[COORD_WIDTH-1:0];
        REG_AXIS_X: regs.ref_axis_x <= cfg.wdata[AXIS_WIDTH-1:0];
        REG_AXIS_Y: regs.ref_axis_y <= cfg.wdata[AXIS_WIDTH-1:0];
        REG_HALF_W: regs.ref_half_w <= cfg.wdata[LEN_WIDTH-1:0];
        REG_HALF_D: regs.ref_half_d <= cfg.wdata[LEN_WIDTH-1:0];
        REG_RADIUS: regs.ref_radius <= cfg.wdata[LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    work = '0;
    work.point = in_data.req_type;
    work.dx = DELTA_WIDTH'(regs.ref_x) - DELTA_WIDTH'(in_data.other_x);
    work.dy = DELTA_WIDTH'(regs.ref_y) - DELTA_WIDTH'(in_data.other_y);
    work.ax = regs.ref_axis_x;
    work.ay = regs.ref_axis_y;
    work.aw = regs.ref_half_w;
    work.ad = regs.ref_half_d;
    work.bx = in_data.other_axis_x;
    work.by = in_data.other_axis_y;
    work.bw = in_data.other_half_w;
    work.bd = in_data.other_half_d;
    if (in_data.req_type) begin
      work.reach = {1'b0, regs.ref_radius};
      work.grow  = '0;
      work.kind  = regs.ref_type ? KIND_RB : KIND_CC;
    end else begin
      work.reach = {1'b0, regs.ref_radius} + {1'b0, in_data.other_radius};
      unique case ({regs.ref_type, in_data.other_type})
        2'b00: begin
          work.kind = KIND_CC;
          work.grow = '0;
        end
        2'b10: begin
          work.kind = KIND_RB;
          work.grow = {1'b0, in_data.other_radius};
        end
        2'b01: begin
          // test the other box grown by the reference radius
          work.kind = KIND_OB;
          work.grow = {1'b0, regs.ref_radius};
          work.ax = in_data.other_axis_x;
          work.ay = in_data.other_axis_y;
          work.aw = in_data.other_half_w;
          work.ad = in_data.other_half_d;
        end
        default: begin
          work.kind = KIND_BB;
          work.grow = '0;
        end
      endcase
    end
  end

endmodule

/* src/cobb_queue.sv */
// ----------------------------------------------------------------------------
// cobb_queue
// two-entry fifo between the front and the back
// ----------------------------------------------------------------------------
module cobb_queue import cobb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  output logic  not_empty,
  input  logic  pop,
  output work_t pop_data
);

  work_t                mem [QDEPTH];
  logic [QPTR_WIDTH-1:0] wptr;
  logic [QPTR_WIDTH-1:0] rptr;
  logic [QPTR_WIDTH:0]   count;

  assign full      = (count == (QPTR_WIDTH+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QPTR_WIDTH+1)'(push) - (QPTR_WIDTH+1)'(pop);
    end
  end

endmodule

/* src/cobb_back.sv */
// ----------------------------------------------------------------------------
// cobb_back
// three-stage evaluator: products, rounded extents, compares into result register
// ----------------------------------------------------------------------------
module cobb_back import cobb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  work_t      in_data,
  cobb_res_if.source res
);

  typedef logic signed [PROJ_WIDTH-1:0] proj_t;
  typedef logic signed [CMP_WIDTH-1:0]  cmp_t;
  typedef logic signed [EXT_WIDTH-1:0]  ext_t;

  function automatic logic signed [RDOT_WIDTH-1:0] round14(
      input logic signed [DOT_WIDTH-1:0] v);
    logic [DOT_WIDTH-1:0] m;
    logic [DOT_WIDTH-1:0] r;
    m = v[DOT_WIDTH-1] ? DOT_WIDTH'(-v) : DOT_WIDTH'(v);
    r = (m + DOT_WIDTH'(1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
    return v[DOT_WIDTH-1] ? -RDOT_WIDTH'(r) : RDOT_WIDTH'(r);
  endfunction

  function automatic logic [CMP_WIDTH-1:0] mag(input cmp_t v);
    return v[CMP_WIDTH-1] ? CMP_WIDTH'(-v) : CMP_WIDTH'(v);
  endfunction

  // stage 1: squares, projections and axis dot products
  logic                        v1;
  kind_t                       kind1;
  logic                        point1;
  logic [SQ_WIDTH-1:0]         dist1;
  logic [SQ_WIDTH-1:0]         reach1;
  proj_t                       pu1, pv1, qu1, qv1;
  logic signed [DOT_WIDTH-1:0] cr1, dt1;
  logic [LEN_WIDTH-1:0]        aw1, ad1, bw1, bd1;
  logic [LEN_WIDTH:0]          grow1;

  // stage 2: projected extents, bounding and extent decisions
  logic                 v2;
  kind_t                kind2;
  logic                 point2;
  logic                 near2, in_box2;
  proj_t                pu2, pv2, qu2, qv2;
  logic [LEN_WIDTH-1:0] aw2, ad2, bw2, bd2;
  ext_t                 e_ud2, e_vw2, e_uw2, e_vd2;
  ext_t                 e_ua2, e_vaw2, e_uaw2, e_vad2;

  // stage 3: separating axis compares, result register
  logic v3;
  logic hit3;

  logic adv3, adv2, adv1;
  assign adv3     = !v3 || res.ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      kind1  <= in_data.kind;
      point1 <= in_data.point;
      dist1  <= SQ_WIDTH'(in_data.dx * in_data.dx) + SQ_WIDTH'(in_data.dy * in_data.dy);
      reach1 <= SQ_WIDTH'(in_data.reach * in_data.reach);
      pu1 <= PROJ_WIDTH'(in_data.dx * in_data.ax) + PROJ_WIDTH'(in_data.dy * in_data.ay);
      pv1 <= PROJ_WIDTH'(in_data.dx * in_data.ay) - PROJ_WIDTH'(in_data.dy * in_data.ax);
      qu1 <= PROJ_WIDTH'(in_data.dx * in_data.bx) + PROJ_WIDTH'(in_data.dy * in_data.by);
      qv1 <= PROJ_WIDTH'(in_data.dx * in_data.by) - PROJ_WIDTH'(in_data.dy * in_data.bx);
      cr1 <= DOT_WIDTH'(in_data.ax * in_data.by) - DOT_WIDTH'(in_data.ay * in_data.bx);
      dt1 <= DOT_WIDTH'(in_data.ax * in_data.bx) + DOT_WIDTH'(in_data.ay * in_data.by);
      aw1 <= in_data.aw;
      ad1 <= in_data.ad;
      bw1 <= in_data.bw;
      bd1 <= in_data.bd;
      grow1 <= in_data.grow;
    end
  end

  logic signed [RDOT_WIDTH-1:0] uv, uu;
  logic                         near, in_box, sep;

  function automatic logic apart(input proj_t dm, input ext_t p, input ext_t q,
                                 input logic [LEN_WIDTH-1:0] ext);
    logic [CMP_WIDTH-1:0] p1, p2, pm;
    p1 = mag(CMP_WIDTH'(p) + CMP_WIDTH'(q));
    p2 = mag(CMP_WIDTH'(p) - CMP_WIDTH'(q));
    pm = (p1 > p2) ? p1 : p2;
    return $signed(mag(CMP_WIDTH'(dm)) - pm) >
           $signed(CMP_WIDTH'({ext, {AXIS_FRAC{1'b0}}}));
  endfunction

  always_comb begin
    uv   = round14(cr1);
    uu   = round14(dt1);
    near = (dist1 <= reach1);
    in_box = (mag(CMP_WIDTH'(pu1)) <=
              CMP_WIDTH'({(LEN_WIDTH+1)'(ad1) + grow1, {AXIS_FRAC{1'b0}}})) &&
             (mag(CMP_WIDTH'(pv1)) <=
              CMP_WIDTH'({(LEN_WIDTH+1)'(aw1) + grow1, {AXIS_FRAC{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      kind2   <= kind1;
      point2  <= point1;
      near2   <= near;
      in_box2 <= in_box;
      pu2 <= pu1;
      pv2 <= pv1;
      qu2 <= qu1;
      qv2 <= qv1;
      aw2 <= aw1;
      ad2 <= ad1;
      bw2 <= bw1;
      bd2 <= bd1;
      e_ud2  <= EXT_WIDTH'(uu * $signed({1'b0, bd1}));
      e_vw2  <= EXT_WIDTH'(uv * $signed({1'b0, bw1}));
      e_uw2  <= EXT_WIDTH'(uu * $signed({1'b0, bw1}));
      e_vd2  <= EXT_WIDTH'(uv * $signed({1'b0, bd1}));
      e_ua2  <= EXT_WIDTH'(uu * $signed({1'b0, ad1}));
      e_vaw2 <= EXT_WIDTH'(uv * $signed({1'b0, aw1}));
      e_uaw2 <= EXT_WIDTH'(uu * $signed({1'b0, aw1}));
      e_vad2 <= EXT_WIDTH'(uv * $signed({1'b0, ad1}));
    end
  end

  always_comb begin
    // vu = -uv, vv = uu
    sep = apart(pv2, -e_vd2, e_uw2, aw2) ||
          apart(pu2, e_ud2, e_vw2, ad2) ||
          apart(qv2, e_vad2, e_uaw2, bw2) ||
          apart(qu2, e_ua2, e_vaw2, bd2);
    if (sep && point2) sep = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      unique case (kind2)
        KIND_CC: hit3 <= near2;
        KIND_RB: hit3 <= near2 && in_box2;
        KIND_OB: hit3 <= near2 && in_box2;
        KIND_BB: hit3 <= near2 && !sep;
        default: hit3 <= 1'b0;
      endcase
    end
  end

  assign res.valid = v3;
  assign res.hit   = hit3;

endmodule

/* src/circle_obb_overlap_test_top.sv */
// ----------------------------------------------------------------------------
// circle_obb_overlap_test_top
// overlap and containment tester of a reference circle or box against items
// an accepted item passes through the queue and the three stages before result valid
// throughput: one item per cycle, back to back; input stalls only under result back pressure
// reset: synchronous; registers return to reset values, queue and stages empty
// ----------------------------------------------------------------------------
module circle_obb_overlap_test_top import cobb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cobb_cfg_if.sink  cfg,
  cobb_req_if.sink  req,
  cobb_res_if.source res
);

  work_t work_in, work_out;
  logic  full, not_empty, back_ready;

  assign req.ready = !full;

  cobb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_data  (req.data),
    .work     (work_in)
  );

  cobb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req.valid && !full),
    .push_data (work_in),
    .full      (full),
    .not_empty (not_empty),
    .pop       (not_empty && back_ready),
    .pop_data  (work_out)
  );

  cobb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (not_empty),
    .in_ready (back_ready),
    .in_data  (work_out),
    .res      (res)
  );

endmodule

/* src/cobb_checker.sv */
// ----------------------------------------------------------------------------
// cobb_checker
// port-level checks of the overlap tester
// ----------------------------------------------------------------------------
module cobb_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_hit
);

  a_no_out_after_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
      res_valid && !res_ready |=> res_valid && $stable(res_hit))
    else $error("stalled result changed");
  a_latency: assert property (@(posedge clk) disable iff (rst)
      req_valid && req_ready && res_ready && !res_valid |-> ##4 res_valid)
    else $error("no result four cycles after idle accept");

endmodule

bind circle_obb_overlap_test_top cobb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_hit   (res.hit)
);
